### rtl/core/cpd_pkg.sv
// Shared types and constants for the Pearson correlation distance unit.
package cpd_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 65536;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SUM_W    = 33;
  localparam int unsigned SQ_W     = 47;
  localparam int unsigned CROSS_W  = 48;
  localparam int unsigned COEF_W   = 33;
  localparam int unsigned ROOT_W   = 31;

  localparam int unsigned DIV_STEPS  = 60;
  localparam int unsigned SQRT_STEPS = 32;

  localparam logic [COEF_W-1:0] ONE_Q30 = COEF_W'(1) << 30;

  // where a registered partial product goes
  typedef enum logic [1:0] {
    DST_ACC,
    DST_SXX,
    DST_SYY,
    DST_SXY
  } dest_e;

  typedef struct packed {
    logic       valid;
    dest_e      dest;
    logic [1:0] shift;   // in 32-bit words
    logic       neg;
  } mul_tag_t;

endpackage

### rtl/core/cpd_if.sv
// Stream interfaces for sample words and result words.
interface cpd_in_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  x_sample;
  logic signed [15:0]  y_sample;
  logic                last_pair;

  modport source (output valid, output x_sample, output y_sample, output last_pair,
                  input ready);
  modport sink   (input valid, input x_sample, input y_sample, input last_pair,
                  output ready);
endinterface

interface cpd_out_if;
  logic                valid;
  logic                ready;
  logic signed [32:0]  coefficient;
  logic                undefined;

  modport source (output valid, output coefficient, output undefined, input ready);
  modport sink   (input valid, input coefficient, input undefined, output ready);
endinterface

### rtl/core/cpd_mul32.sv
// Shared 32x32 unsigned multiplier with registered product and tag.
module cpd_mul32 import cpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  mul_tag_t    tag_i,
  output logic [63:0] prod_o,
  output mul_tag_t    tag_o
);

  logic [63:0] prod_d, prod_q;
  mul_tag_t    tag_q;

  assign prod_d = a_i * b_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;
  assign tag_o  = tag_q;

endmodule

### rtl/core/cpd_root.sv
// Iterative restoring divide (Q60 ratio) followed by integer square root.
module cpd_root import cpd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [63:0]       num_i,
  input  logic [63:0]       den_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  typedef enum logic [1:0] {
    R_IDLE,
    R_DIV,
    R_SQRT
  } rstate_e;

  rstate_e     state_q;
  logic [5:0]  cnt_q;
  logic [63:0] rem_q, den_q, quo_q, res_q, bit_q;
  logic        done_q;

  logic [64:0] sub_a, sub_b;
  logic [65:0] diff;
  logic        ge;
  logic [63:0] res_bit;

  assign res_bit = res_q + bit_q;

  // one subtractor serves both the divide and the root steps
  always_comb begin
    if (state_q == R_DIV) begin
      sub_a = {rem_q, 1'b0};
      sub_b = {1'b0, den_q};
    end else begin
      sub_a = {1'b0, rem_q};
      sub_b = {1'b0, res_bit};
    end
    diff = {1'b0, sub_a} - {1'b0, sub_b};
    ge   = ~diff[65];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        R_IDLE: begin
          if (start_i) begin
            den_q <= den_i;
            cnt_q <= '0;
            if (num_i >= den_i) begin
              rem_q   <= 64'd1 << 60;
              res_q   <= '0;
              bit_q   <= 64'd1 << 62;
              state_q <= R_SQRT;
            end else begin
              rem_q   <= num_i;
              quo_q   <= '0;
              state_q <= R_DIV;
            end
          end
        end
        R_DIV: begin
          if (ge) begin
            rem_q <= diff[63:0];
            quo_q <= {quo_q[62:0], 1'b1};
          end else begin
            rem_q <= {rem_q[62:0], 1'b0};
            quo_q <= {quo_q[62:0], 1'b0};
          end
          if (cnt_q == 6'(DIV_STEPS - 1)) begin
            cnt_q   <= '0;
            state_q <= R_SQRT;
            res_q   <= '0;
            bit_q   <= 64'd1 << 62;
            // last quotient bit lands here too
            rem_q   <= ge ? {quo_q[62:0], 1'b1} : {quo_q[62:0], 1'b0};
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        R_SQRT: begin
          if (ge) begin
            rem_q <= diff[63:0];
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (cnt_q == 6'(SQRT_STEPS - 1)) begin
            cnt_q   <= '0;
            done_q  <= 1'b1;
            state_q <= R_IDLE;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        default: state_q <= R_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[ROOT_W-1:0];

endmodule

### rtl/core/pearson_correlation_distance_unit.sv
// Pearson correlation / distance unit: top level with sample sums and sequencer.
// For each (x, y) word the three products x*x, y*y and x*y go through one
// shared 32x32 multiplier. The word marked last adds its pair and then
// computes r (or 1 - r) in Q2.30: a check state, 8 wide products on the same
// multiplier, a normalizing shift, then a 60-step divide and a 32-step square
// root in the root unit before the result word is offered. The result word
// sits in its own output register, so the next set can start while it waits.
// Fewer than two samples, zero variance or more samples than MAX_SAMPLES
// give undefined = 1 with coefficient 0. Sums clear after every result.
module pearson_correlation_distance_unit import cpd_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  cpd_in_if.sink        in_i,
  cpd_out_if.source     out_o
);

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ITEM,
    ST_CHECK,
    ST_TERM,
    ST_NORM,
    ST_ROOT,
    ST_OUT
  } state_e;

  localparam logic [2:0] TRM_NXX = 3'd0;
  localparam logic [2:0] TRM_VX  = 3'd1;
  localparam logic [2:0] TRM_NYY = 3'd2;
  localparam logic [2:0] TRM_VY  = 3'd3;
  localparam logic [2:0] TRM_NXY = 3'd4;
  localparam logic [2:0] TRM_COV = 3'd5;
  localparam logic [2:0] TRM_T   = 3'd6;
  localparam logic [2:0] TRM_P   = 3'd7;

  state_e              state_q;
  logic [2:0]          ph_q, term_q;
  logic                dist_q;
  logic [CNT_W-1:0]    count_q;
  logic [SUM_W-1:0]    sx_q, sy_q;
  logic [SQ_W-1:0]     sxx_q, syy_q;
  logic [CROSS_W-1:0]  sxy_q;
  logic                ovf_q, last_q;
  logic [15:0]         xmag_q, ymag_q;
  logic                xneg_q, yneg_q;
  logic [127:0]        acc_q, t_q, p_q;
  logic [63:0]         vx_q, vy_q, covmag_q;
  logic                covneg_q, undef_q;
  logic                out_valid_q;
  logic [COEF_W-1:0]   coef_q;
  logic [COEF_W-1:0]   out_coef_q;
  logic                out_undef_q;

  logic                accept;
  logic [31:0]         mul_a, mul_b;
  mul_tag_t            issue, mtag;
  logic [63:0]         mprod;
  logic [63:0]         op_a, op_b;
  logic                op_neg, term_end;
  logic [127:0]        prod_sh, acc_add;
  logic [31:0]         sx_mag, sy_mag;
  logic [SUM_W-1:0]    sx_abs, sy_abs;
  logic [CROSS_W-1:0]  sxy_abs;
  logic [15:0]         x_abs, y_abs;
  logic                root_start, root_done;
  logic [ROOT_W-1:0]   root;
  logic [COEF_W-1:0]   r_signed, r_final;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  assign x_abs  = in_i.x_sample[15] ? 16'(~in_i.x_sample + 16'd1) : in_i.x_sample;
  assign y_abs  = in_i.y_sample[15] ? 16'(~in_i.y_sample + 16'd1) : in_i.y_sample;
  assign sx_abs = sx_q[SUM_W-1] ? ~sx_q + SUM_W'(1) : sx_q;
  assign sy_abs = sy_q[SUM_W-1] ? ~sy_q + SUM_W'(1) : sy_q;
  assign sx_mag = sx_abs[31:0];
  assign sy_mag = sy_abs[31:0];
  assign sxy_abs = sxy_q[CROSS_W-1] ? ~sxy_q + CROSS_W'(1) : sxy_q;

  // wide product operands, one term at a time
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_neg = 1'b0;
    case (term_q)
      TRM_NXX: begin op_a = 64'(count_q); op_b = 64'(sxx_q); end
      TRM_VX:  begin op_a = 64'(sx_mag);  op_b = 64'(sx_mag); op_neg = 1'b1; end
      TRM_NYY: begin op_a = 64'(count_q); op_b = 64'(syy_q); end
      TRM_VY:  begin op_a = 64'(sy_mag);  op_b = 64'(sy_mag); op_neg = 1'b1; end
      TRM_NXY: begin
        op_a = 64'(count_q); op_b = 64'(sxy_abs); op_neg = sxy_q[CROSS_W-1];
      end
      TRM_COV: begin
        op_a = 64'(sx_mag); op_b = 64'(sy_mag);
        op_neg = ~(sx_q[SUM_W-1] ^ sy_q[SUM_W-1]);
      end
      TRM_T:   begin op_a = covmag_q; op_b = covmag_q; end
      TRM_P:   begin op_a = vx_q;     op_b = vy_q; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    issue = '0;
    if (state_q == ST_ITEM) begin
      case (ph_q)
        3'd0: begin
          mul_a = 32'(xmag_q); mul_b = 32'(xmag_q);
          issue = '{valid: 1'b1, dest: DST_SXX, shift: 2'd0, neg: 1'b0};
        end
        3'd1: begin
          mul_a = 32'(ymag_q); mul_b = 32'(ymag_q);
          issue = '{valid: 1'b1, dest: DST_SYY, shift: 2'd0, neg: 1'b0};
        end
        3'd2: begin
          mul_a = 32'(xmag_q); mul_b = 32'(ymag_q);
          issue = '{valid: 1'b1, dest: DST_SXY, shift: 2'd0, neg: xneg_q ^ yneg_q};
        end
        default: issue = '0;
      endcase
    end else if (state_q == ST_TERM && ph_q != 3'd4) begin
      mul_a = ph_q[0] ? op_a[63:32] : op_a[31:0];
      mul_b = ph_q[1] ? op_b[63:32] : op_b[31:0];
      issue = '{valid: 1'b1, dest: DST_ACC,
                shift: 2'(ph_q[0]) + 2'(ph_q[1]), neg: op_neg};
    end
  end

  cpd_mul32 u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .tag_i  (issue),
    .prod_o (mprod),
    .tag_o  (mtag)
  );

  assign prod_sh  = 128'(mprod) << {mtag.shift, 5'b0};
  assign acc_add  = mtag.neg ? acc_q - prod_sh : acc_q + prod_sh;
  assign term_end = (state_q == ST_TERM) && (ph_q == 3'd4) &&
                    (term_q == TRM_VX || term_q == TRM_VY || term_q == TRM_COV ||
                     term_q == TRM_T || term_q == TRM_P);

  assign root_start = (state_q == ST_NORM) && (p_q[127:64] == '0);

  cpd_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .num_i   (t_q[63:0]),
    .den_i   (p_q[63:0]),
    .done_o  (root_done),
    .root_o  (root)
  );

  always_comb begin
    r_signed = covneg_q ? ~COEF_W'(root) + COEF_W'(1) : COEF_W'(root);
    r_final  = dist_q ? ONE_Q30 - r_signed : r_signed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= '0;
      term_q      <= '0;
      dist_q      <= 1'b1;
      count_q     <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      sxx_q       <= '0;
      syy_q       <= '0;
      sxy_q       <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      acc_q       <= '0;
      undef_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_coef_q  <= '0;
      out_undef_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dist_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      // registered products land in their sums
      if (mtag.valid) begin
        case (mtag.dest)
          DST_SXX: sxx_q <= sxx_q + SQ_W'(mprod);
          DST_SYY: syy_q <= syy_q + SQ_W'(mprod);
          DST_SXY: sxy_q <= mtag.neg ? sxy_q - CROSS_W'(mprod) : sxy_q + CROSS_W'(mprod);
          default: acc_q <= term_end ? '0 : acc_add;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            last_q <= in_i.last_pair;
            if (count_q < CNT_W'(MAX_SAMPLES)) begin
              count_q <= count_q + CNT_W'(1);
              sx_q    <= sx_q + SUM_W'(in_i.x_sample);
              sy_q    <= sy_q + SUM_W'(in_i.y_sample);
              xmag_q  <= x_abs;
              ymag_q  <= y_abs;
              xneg_q  <= in_i.x_sample[15];
              yneg_q  <= in_i.y_sample[15];
              ph_q    <= '0;
              state_q <= ST_ITEM;
            end else begin
              ovf_q <= 1'b1;
              if (in_i.last_pair) begin
                state_q <= ST_CHECK;
              end
            end
          end
        end
        ST_ITEM: begin
          if (ph_q == 3'd3) begin
            state_q <= last_q ? ST_CHECK : ST_IDLE;
          end else begin
            ph_q <= ph_q + 3'd1;
          end
        end
        ST_CHECK: begin
          ph_q   <= '0;
          term_q <= '0;
          if (ovf_q || count_q < CNT_W'(2)) begin
            undef_q <= 1'b1;
            state_q <= ST_OUT;
          end else begin
            undef_q <= 1'b0;
            state_q <= ST_TERM;
          end
        end
        ST_TERM: begin
          if (ph_q == 3'd4) begin
            ph_q   <= '0;
            term_q <= term_q + 3'd1;
            case (term_q)
              TRM_VX: vx_q <= acc_add[63:0];
              TRM_VY: begin
                vy_q <= acc_add[63:0];
                if (vx_q == '0 || acc_add[63:0] == '0) begin
                  undef_q <= 1'b1;
                  state_q <= ST_OUT;
                end
              end
              TRM_COV: begin
                covneg_q <= acc_add[127];
                covmag_q <= acc_add[127] ? ~acc_add[63:0] + 64'd1 : acc_add[63:0];
              end
              TRM_T: t_q <= acc_add;
              TRM_P: begin
                p_q     <= acc_add;
                state_q <= ST_NORM;
              end
              default: ;
            endcase
          end else begin
            ph_q <= ph_q + 3'd1;
          end
        end
        ST_NORM: begin
          if (p_q[127:64] != '0) begin
            t_q <= t_q >> 1;
            p_q <= p_q >> 1;
          end else begin
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (root_done) begin
            coef_q  <= r_final;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_coef_q  <= undef_q ? '0 : coef_q;
            out_undef_q <= undef_q;
            count_q <= '0;
            sx_q    <= '0;
            sy_q    <= '0;
            sxx_q   <= '0;
            syy_q   <= '0;
            sxy_q   <= '0;
            ovf_q   <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.coefficient = out_coef_q;
  assign out_o.undefined   = out_undef_q;

endmodule
